### sv/qrs_pkg.sv
// ============================================================================
// qrs_pkg: quadratic root solver shared types and helpers
// Result layout, kind codes and the per-stage step functions of the
// square-root and divider pipelines.
// ============================================================================
`default_nettype none

package qrs_pkg;

   // root kind codes
   localparam logic [1:0] KIND_TWO_REAL = 2'd0;
   localparam logic [1:0] KIND_ONE_REAL = 2'd1;
   localparam logic [1:0] KIND_COMPLEX  = 2'd2;
   localparam logic [1:0] KIND_ERROR    = 2'd3;

   // square root: 62-bit radicand, one result bit per stage
   localparam int SqrtSteps = 31;
   // divider: 34-bit dividend magnitude, one quotient bit per stage
   localparam int DivSteps  = 34;

   typedef struct packed {
      logic [1:0]         root_kind;
      logic signed [31:0] root1_real;
      logic signed [31:0] root1_imag;
      logic signed [31:0] root2_real;
      logic signed [31:0] root2_imag;
      logic               saturated;
   } result_type;

   // fields that ride along the square-root pipeline
   typedef struct packed {
      logic [1:0]         kind;
      logic               a_neg;
      logic [15:0]        a_mag;
      logic signed [30:0] nb;
   } side_type;

   typedef struct packed {
      logic [61:0] rad;
      logic [32:0] rem;
      logic [30:0] root;
      side_type    side;
   } sq_type;

   typedef struct packed {
      logic [33:0] w;     // dividend bits shift out the top, quotient bits in
      logic [15:0] rem;
      logic        neg;
   } lane_type;

   typedef struct packed {
      lane_type    l1;
      lane_type    l2;
      lane_type    l3;    // imaginary magnitude, sign of +s
      logic [1:0]  kind;
      logic [15:0] dmag;
   } dv_type;

   typedef struct packed {
      logic [31:0] v;
      logic        sat;
   } part_type;

   // one bit of the digit-by-digit integer square root
   function automatic sq_type sqrt_step(input sq_type s);
      logic [34:0] cur;
      logic [34:0] trial;
      sq_type      r;
      r     = s;
      cur   = {s.rem, s.rad[61:60]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[59:0], 2'b00};
      if (cur >= trial) begin
         r.rem  = 33'(cur - trial);
         r.root = {s.root[29:0], 1'b1};
      end else begin
         r.rem  = cur[32:0];
         r.root = {s.root[29:0], 1'b0};
      end
      return r;
   endfunction

   // one bit of restoring unsigned division
   function automatic lane_type div_step(input lane_type l, input logic [15:0] d);
      logic [16:0] cur;
      logic        qb;
      lane_type    r;
      r   = l;
      cur = {l.rem, l.w[33]};
      qb  = (cur >= {1'b0, d});
      r.w = {l.w[32:0], qb};
      if (qb) begin
         r.rem = 16'(cur - {1'b0, d});
      end else begin
         r.rem = cur[15:0];
      end
      return r;
   endfunction

   // apply sign to a quotient magnitude and clip to 32 bits
   function automatic part_type sat_part(input logic [33:0] q, input logic neg);
      part_type p;
      if (!neg) begin
         if (q[33:31] != 3'd0) begin
            p.v   = 32'h7fff_ffff;
            p.sat = 1'b1;
         end else begin
            p.v   = q[31:0];
            p.sat = 1'b0;
         end
      end else begin
         if (q > 34'h0_8000_0000) begin
            p.v   = 32'h8000_0000;
            p.sat = 1'b1;
         end else begin
            p.v   = 32'(-q[31:0]);
            p.sat = 1'b0;
         end
      end
      return p;
   endfunction

endpackage

`default_nettype wire

### sv/qrs_if.sv
// ============================================================================
// qrs channel interfaces
// Coefficient request channel and root response channel, valid/ready.
// ============================================================================
`default_nettype none

interface qrs_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] coef_a;
   logic signed [15:0] coef_b;
   logic signed [15:0] coef_c;
   logic signed [15:0] rhs_d;

   modport source (output valid, coef_a, coef_b, coef_c, rhs_d, input ready);
   modport sink   (input valid, coef_a, coef_b, coef_c, rhs_d, output ready);
endinterface

interface qrs_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         root_kind;
   logic signed [31:0] root1_real;
   logic signed [31:0] root1_imag;
   logic signed [31:0] root2_real;
   logic signed [31:0] root2_imag;
   logic               saturated;

   modport source (output valid, root_kind, root1_real, root1_imag, root2_real,
                   root2_imag, saturated, input ready);
   modport sink   (input valid, root_kind, root1_real, root1_imag, root2_real,
                   root2_imag, saturated, output ready);
endinterface

`default_nettype wire

### sv/qrs_datapath.sv
// ============================================================================
// qrs_datapath: pipelined quadratic root arithmetic
// Discriminant, 31-stage square root, three 34-stage dividers, saturation.
// All stages advance together on en.
// ============================================================================
`default_nettype none

module qrs_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic signed [15:0] coef_a,
   input  wire logic signed [15:0] coef_b,
   input  wire logic signed [15:0] coef_c,
   input  wire logic signed [15:0] rhs_d,
   output logic                    out_valid,
   output qrs_pkg::result_type     out_data
);

   localparam int SqN = qrs_pkg::SqrtSteps;
   localparam int DvN = qrs_pkg::DivSteps;

   // stage 0: operands
   logic               s0_valid_ff;
   logic signed [15:0] s0_a_ff, s0_b_ff;
   logic signed [16:0] s0_k_ff;
   // stage 1: products
   logic               s1_valid_ff;
   logic signed [15:0] s1_a_ff, s1_b_ff;
   logic signed [31:0] s1_bb_ff;
   logic signed [32:0] s1_ak_ff;
   // stage 2: discriminant magnitude and kind
   logic               s2_valid_ff;
   qrs_pkg::sq_type    s2_ff, s2_in;
   // square root and divider stages
   logic [SqN-1:0]     sq_valid_ff;
   qrs_pkg::sq_type    sq_ff [SqN];
   logic [DvN-1:0]     dv_valid_ff;
   qrs_pkg::dv_type    dv_ff [DvN];
   qrs_pkg::dv_type    dv_in;
   // output stage
   logic               out_valid_ff;
   qrs_pkg::result_type out_ff, out_in;

   // form the discriminant, its magnitude and the root kind
   always_comb begin
      logic signed [34:0] disc;
      logic [34:0]        mag;
      disc = 35'(s1_bb_ff) - (35'(s1_ak_ff) <<< 2);
      mag  = disc[34] ? 35'(-disc) : disc;
      s2_in.rad  = {mag[33:0], 28'd0};
      s2_in.rem  = '0;
      s2_in.root = '0;
      s2_in.side.a_neg = s1_a_ff[15];
      s2_in.side.a_mag = s1_a_ff[15] ? 16'(-s1_a_ff) : 16'(s1_a_ff);
      s2_in.side.nb    = 31'(-(17'(s1_b_ff))) <<< 14;
      if (s1_a_ff == 16'sd0) begin
         s2_in.side.kind  = qrs_pkg::KIND_ERROR;
         s2_in.side.a_mag = 16'd1;
      end else if (disc[34]) begin
         s2_in.side.kind = qrs_pkg::KIND_COMPLEX;
      end else if (disc == 35'sd0) begin
         s2_in.side.kind = qrs_pkg::KIND_ONE_REAL;
      end else begin
         s2_in.side.kind = qrs_pkg::KIND_TWO_REAL;
      end
   end

   // build the three divider numerators from the square root
   always_comb begin
      qrs_pkg::sq_type    q;
      logic signed [32:0] nb, s, n1, n2;
      logic [32:0]        m1, m2;
      q  = sq_ff[SqN-1];
      nb = 33'(q.side.nb);
      s  = {2'b00, q.root};
      n1 = (q.side.kind == qrs_pkg::KIND_TWO_REAL) ? nb - s : nb;
      n2 = (q.side.kind == qrs_pkg::KIND_TWO_REAL) ? nb + s : nb;
      m1 = n1[32] ? 33'(-n1) : n1;
      m2 = n2[32] ? 33'(-n2) : n2;
      dv_in.l1.w   = {m1, 1'b0};
      dv_in.l1.rem = '0;
      dv_in.l1.neg = n1[32] ^ q.side.a_neg;
      dv_in.l2.w   = {m2, 1'b0};
      dv_in.l2.rem = '0;
      dv_in.l2.neg = n2[32] ^ q.side.a_neg;
      dv_in.l3.w   = {1'b0, s[31:0], 1'b0};
      dv_in.l3.rem = '0;
      dv_in.l3.neg = q.side.a_neg;
      dv_in.kind   = q.side.kind;
      dv_in.dmag   = q.side.a_mag;
   end

   // sign, clip and place the root parts
   always_comb begin
      qrs_pkg::dv_type   d;
      qrs_pkg::part_type p1, p2, pi1, pi2;
      d   = dv_ff[DvN-1];
      p1  = qrs_pkg::sat_part(d.l1.w, d.l1.neg);
      p2  = qrs_pkg::sat_part(d.l2.w, d.l2.neg);
      pi1 = qrs_pkg::sat_part(d.l3.w, ~d.l3.neg);
      pi2 = qrs_pkg::sat_part(d.l3.w, d.l3.neg);
      out_in.root_kind  = d.kind;
      out_in.root1_real = p1.v;
      out_in.root2_real = p2.v;
      out_in.root1_imag = '0;
      out_in.root2_imag = '0;
      out_in.saturated  = p1.sat | p2.sat;
      case (d.kind)
         qrs_pkg::KIND_TWO_REAL, qrs_pkg::KIND_ONE_REAL: begin
         end
         qrs_pkg::KIND_COMPLEX: begin
            out_in.root1_imag = pi1.v;
            out_in.root2_imag = pi2.v;
            out_in.saturated  = p1.sat | pi1.sat | pi2.sat;
         end
         default: begin
            out_in.root1_real = '0;
            out_in.root2_real = '0;
            out_in.saturated  = 1'b0;
         end
      endcase
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         sq_valid_ff  <= '0;
         dv_valid_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff  <= in_valid;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         sq_valid_ff  <= {sq_valid_ff[SqN-2:0], s2_valid_ff};
         dv_valid_ff  <= {dv_valid_ff[DvN-2:0], sq_valid_ff[SqN-1]};
         out_valid_ff <= dv_valid_ff[DvN-1];
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         s0_a_ff  <= coef_a;
         s0_b_ff  <= coef_b;
         s0_k_ff  <= 17'(coef_c) - 17'(rhs_d);
         s1_a_ff  <= s0_a_ff;
         s1_b_ff  <= s0_b_ff;
         s1_bb_ff <= s0_b_ff * s0_b_ff;
         s1_ak_ff <= 33'(s0_a_ff) * 33'(s0_k_ff);
         s2_ff    <= s2_in;
         sq_ff[0] <= qrs_pkg::sqrt_step(s2_ff);
         for (int i = 1; i < SqN; i++) begin
            sq_ff[i] <= qrs_pkg::sqrt_step(sq_ff[i-1]);
         end
         dv_ff[0].l1   <= qrs_pkg::div_step(dv_in.l1, dv_in.dmag);
         dv_ff[0].l2   <= qrs_pkg::div_step(dv_in.l2, dv_in.dmag);
         dv_ff[0].l3   <= qrs_pkg::div_step(dv_in.l3, dv_in.dmag);
         dv_ff[0].kind <= dv_in.kind;
         dv_ff[0].dmag <= dv_in.dmag;
         for (int i = 1; i < DvN; i++) begin
            dv_ff[i].l1   <= qrs_pkg::div_step(dv_ff[i-1].l1, dv_ff[i-1].dmag);
            dv_ff[i].l2   <= qrs_pkg::div_step(dv_ff[i-1].l2, dv_ff[i-1].dmag);
            dv_ff[i].l3   <= qrs_pkg::div_step(dv_ff[i-1].l3, dv_ff[i-1].dmag);
            dv_ff[i].kind <= dv_ff[i-1].kind;
            dv_ff[i].dmag <= dv_ff[i-1].dmag;
         end
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

`default_nettype wire

### sv/quadratic_root_solver_top.sv
// ============================================================================
// quadratic_root_solver_top: roots of a*x^2 + b*x + c = d
// Pipelined solver with a two-entry output buffer.
// ============================================================================
//  channel  | dir | payload                                   | transfer
//  ---------+-----+-------------------------------------------+----------------
//  req_ch   | in  | coef_a, coef_b, coef_c, rhs_d (Q8.8)      | valid & ready
//  rsp_ch   | out | root_kind, roots (Q16.16), saturated      | valid & ready
//
//  One item enters per cycle while the output buffer has room; a request
//  passes three arithmetic stages, 31 square-root stages, 34 divider stages
//  and one saturation stage. Reset is synchronous and clears valid bits, the
//  buffer count and the buffer pointers only. The whole pipe holds while the
//  output buffer is full; req_ch.ready depends on the buffer count alone.
// ============================================================================
`default_nettype none

module quadratic_root_solver_top (
   input wire logic   clock,
   input wire logic   reset,
   qrs_req_if.sink    req_ch,
   qrs_rsp_if.source  rsp_ch
);

   logic                en;
   logic                dp_valid;
   qrs_pkg::result_type dp_data;
   logic                push, pop;
   logic [1:0]          cnt_ff, cnt_in;
   logic                wr_ptr_ff, rd_ptr_ff;
   qrs_pkg::result_type buf_ff [2];
   qrs_pkg::result_type head;

   // pipe moves only while the buffer has room
   assign en           = (cnt_ff != 2'd2);
   assign req_ch.ready = en;

   qrs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .coef_a    (req_ch.coef_a),
      .coef_b    (req_ch.coef_b),
      .coef_c    (req_ch.coef_c),
      .rhs_d     (req_ch.rhs_d),
      .out_valid (dp_valid),
      .out_data  (dp_data)
   );

   assign push = dp_valid & en;
   assign pop  = rsp_ch.valid & rsp_ch.ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = 2'(cnt_ff + 2'd1);
      end else if (pop && !push) begin
         cnt_in = 2'(cnt_ff - 2'd1);
      end
   end

   // track buffer occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // store finished results
   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= dp_data;
      end
   end

   assign head              = buf_ff[rd_ptr_ff];
   assign rsp_ch.valid      = (cnt_ff != 2'd0);
   assign rsp_ch.root_kind  = head.root_kind;
   assign rsp_ch.root1_real = head.root1_real;
   assign rsp_ch.root1_imag = head.root1_imag;
   assign rsp_ch.root2_real = head.root2_real;
   assign rsp_ch.root2_imag = head.root2_imag;
   assign rsp_ch.saturated  = head.saturated;

   // buffer never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   // a full buffer with no transfer out stays full and holds the pipe
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> (cnt_ff == 2'd2 && !req_ch.ready))
      else $error("full buffer did not hold");

   // an error result carries all-zero roots
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.root_kind == qrs_pkg::KIND_ERROR) |->
      (rsp_ch.root1_real == 32'sd0 && rsp_ch.root2_real == 32'sd0 &&
       rsp_ch.root1_imag == 32'sd0 && rsp_ch.root2_imag == 32'sd0 &&
       !rsp_ch.saturated))
      else $error("error result with nonzero roots");

endmodule

`default_nettype wire
